@@ src/aligned_sequence_percent_identity_macros.svh @@
// Assertion macros shared by the verification checker of the identity block.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef ALIGNED_SEQUENCE_PERCENT_IDENTITY_MACROS_SVH
`define ALIGNED_SEQUENCE_PERCENT_IDENTITY_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define ASPI_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("aspi assertion failed");

// Condition holds in the cycle after the trigger.
`define ASPI_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("aspi assertion failed");

`endif

@@ src/aspi_pkg.sv @@
// Package of the aligned-sequence percent identity block: word types,
// widths, register indexes and normalizer codes. Depends on nothing.
`default_nettype none

package aspi_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int CNT_W       = 13;
    localparam int PCT_W       = 15;
    localparam int NUM_W       = 28;
    localparam int DEN_W       = 14;
    localparam int CFG_W       = 8;

    localparam logic [PCT_W-1:0] PCT_SCALE = 15'd25600;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLUMNS);

    // Configuration register indexes.
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_GAP  = 1'b1;

    // Normalizer selection codes.
    localparam logic [1:0] MODE_SHORTER   = 2'd0;
    localparam logic [1:0] MODE_MEAN      = 2'd1;
    localparam logic [1:0] MODE_PAIRS     = 2'd2;
    localparam logic [1:0] MODE_POSITIONS = 2'd3;

    localparam logic [1:0] MODE_RESET = MODE_MEAN;
    localparam logic [7:0] GAP_RESET  = 8'd45;

    typedef struct packed {
        logic [7:0] residue_a;
        logic [7:0] residue_b;
        logic       column_selected;
        logic       last_column;
    } t_in_word;

    typedef struct packed {
        logic [PCT_W-1:0] percent_identity;
        logic [CNT_W-1:0] match_count;
        logic             zero_normalizer;
    } t_out_word;

endpackage

`default_nettype wire

@@ src/aspi_div.sv @@
// Restoring divider, one quotient bit per cycle, for the identity block.
// Depends on aspi_pkg for the operand widths.
`default_nettype none

module aspi_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [aspi_pkg::NUM_W-1:0]  i_num,
    input  wire [aspi_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [aspi_pkg::NUM_W-1:0] o_quot
);
    import aspi_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quot;
    logic              r_done;

    logic [DEN_W:0]    partial;
    logic              take;
    logic [DEN_W:0]    diff;

    // The dividend shifts out of the top of r_quot while quotient bits enter below.
    always_comb begin
        partial = {r_rem, r_quot[NUM_W-1]};
        take    = (partial >= {1'b0, r_den});
        diff    = partial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= take ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ src/aligned_sequence_percent_identity.sv @@
// A column without the last flag is counted in the cycle it is accepted. The last
// column leads to its result by way of forming the scaled match count and the
// normalizer, the bit-serial divider and the output register. Throughput: one
// column per cycle, none while operands are formed, the divider runs or a result waits.
// Reset (synchronous, active low) clears the counters, the sequencer and the output
// valid flag, and sets normalization_mode to mean length and gap_symbol to 45.
`default_nettype none

module aligned_sequence_percent_identity (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_index,
    input  wire [aspi_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire aspi_pkg::t_in_word     i_in_word,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output aspi_pkg::t_out_word         o_out_word
);
    import aspi_pkg::*;

    // Sequencer states: counting columns, forming operands, dividing, delivering.
    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;

    logic [1:0]       r_mode;
    logic [7:0]       r_gap;

    logic [CNT_W-1:0] r_matches;
    logic [CNT_W-1:0] r_res_a;
    logic [CNT_W-1:0] r_res_b;
    logic [CNT_W-1:0] r_pairs;
    logic [CNT_W-1:0] r_positions;

    logic [CNT_W-1:0] r_match_hold;
    logic             r_zero;

    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             in_take;
    logic             gap_a;
    logic             gap_b;
    logic             is_match;

    logic [NUM_W-1:0] product;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [PCT_W-1:0] pct;
    logic             out_free;

    // Configuration registers. User writes only while the block is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_gap  <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE: r_mode <= i_cfg_data[1:0];
                REG_GAP:  r_gap  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Column classification against the gap character.
    assign o_in_ready = (r_state == S_RUN);
    assign in_take    = i_in_valid && o_in_ready;
    assign gap_a      = (i_in_word.residue_a == r_gap);
    assign gap_b      = (i_in_word.residue_b == r_gap);
    assign is_match   = i_in_word.column_selected && !gap_a &&
                        (i_in_word.residue_a == i_in_word.residue_b);

    // The counters saturate at the largest supported alignment length. The last
    // column is counted like any other; the counters are cleared once the divider
    // operands have been taken from them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == S_MUL) begin
            r_matches   <= '0;
            r_res_a     <= '0;
            r_res_b     <= '0;
            r_pairs     <= '0;
            r_positions <= '0;
        end else if (in_take) begin
            if (!gap_a && r_res_a < CNT_MAX) begin
                r_res_a <= r_res_a + 1'b1;
            end
            if (!gap_b && r_res_b < CNT_MAX) begin
                r_res_b <= r_res_b + 1'b1;
            end
            if (!(gap_a && gap_b) && r_positions < CNT_MAX) begin
                r_positions <= r_positions + 1'b1;
            end
            if (!gap_a && !gap_b && r_pairs < CNT_MAX) begin
                r_pairs <= r_pairs + 1'b1;
            end
            if (is_match && r_matches < CNT_MAX) begin
                r_matches <= r_matches + 1'b1;
            end
        end
    end

    // Operand formation. For the mean length the scale is doubled and the
    // divisor is the sum of both residue counts, which avoids a half step.
    always_comb begin
        product = NUM_W'(r_matches) * NUM_W'(PCT_SCALE);
        div_num = product;
        div_den = '0;
        unique case (r_mode)
            MODE_SHORTER: begin
                div_den = (r_res_a < r_res_b) ? DEN_W'(r_res_a) : DEN_W'(r_res_b);
            end
            MODE_MEAN: begin
                div_num = {product[NUM_W-2:0], 1'b0};
                div_den = DEN_W'(r_res_a) + DEN_W'(r_res_b);
            end
            MODE_PAIRS:     div_den = DEN_W'(r_pairs);
            MODE_POSITIONS: div_den = DEN_W'(r_positions);
            default:        div_den = '0;
        endcase
    end

    assign div_start = (r_state == S_MUL);

    aspi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // The match count and the zero flag are kept beside the divider.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_match_hold <= r_matches;
            r_zero       <= (div_den == '0);
        end
    end

    // Sequencer.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN:  if (in_take && i_in_word.last_column) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_RUN;
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // The quotient is capped at one hundred percent; a zero normalizer gives zero.
    always_comb begin
        if (r_zero) begin
            pct = '0;
        end else if (div_quot > NUM_W'(PCT_SCALE)) begin
            pct = PCT_SCALE;
        end else begin
            pct = div_quot[PCT_W-1:0];
        end
    end

    // Output register. A new column may be accepted while this word waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_word.percent_identity <= pct;
            r_out_word.match_count      <= r_match_hold;
            r_out_word.zero_normalizer  <= r_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

@@ src/aspi_checker.sv @@
// Port-level checker for the identity block, bound to the top level below.
// Depends on aspi_pkg and the assertion macro header.
`default_nettype none

`include "aligned_sequence_percent_identity_macros.svh"

module aspi_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      i_in_ready,
    input wire aspi_pkg::t_in_word  i_in_word,
    input wire                      i_out_valid,
    input wire                      i_out_ready,
    input wire aspi_pkg::t_out_word i_out_word
);
    import aspi_pkg::*;

    `ASPI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word))
    `ASPI_ASSERT_SAME(a_pct_cap, i_out_valid, i_out_word.percent_identity <= PCT_SCALE)
    `ASPI_ASSERT_SAME(a_zero_pct, i_out_valid && i_out_word.zero_normalizer, i_out_word.percent_identity == '0)
    `ASPI_ASSERT_SAME(a_match_cap, i_out_valid, i_out_word.match_count <= CNT_MAX)
    `ASPI_ASSERT_NEXT(a_busy_after_last, i_in_valid && i_in_ready && i_in_word.last_column, !i_in_ready)

endmodule

bind aligned_sequence_percent_identity aspi_checker u_aspi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);

`default_nettype wire

@@ tb/aligned_sequence_percent_identity_tb.sv @@
// Self-checking testbench for the aligned-sequence percent identity block.
// A directed table and random alignments are scored by a predictor kept in the bench.
// Depends on aspi_pkg and aligned_sequence_percent_identity.
`timescale 1ns / 100ps

module aligned_sequence_percent_identity_tb;

    import aspi_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_WORDS  = 120;
    localparam int N_PHASES     = 5;
    localparam int N_DIRECTED   = 21;

    // One row of the directed table. A row may first load both registers, and
    // it may pin the result that its last column must produce.
    typedef struct packed {
        logic             set_cfg;
        logic [1:0]       mode;
        logic [7:0]       gap;
        logic [7:0]       res_a;
        logic [7:0]       res_b;
        logic             sel;
        logic             last;
        int               reps;
        logic             pin;
        t_out_word        want;
    } t_row;

    // A typed expectation tied to the input word count at which it is produced.
    typedef struct packed {
        int        seq;
        t_out_word word;
    } t_pinned;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        // Reset settings: mean length, gap is '-'. One identical column is 100%.
        '{1'b0, MODE_MEAN, GAP_RESET, "A", "A", 1'b1, 1'b1, 1, 1'b1,
          '{15'd25600, 13'd1, 1'b0}},
        // A column of two gaps leaves every counter at zero.
        '{1'b0, MODE_MEAN, GAP_RESET, GAP_RESET, GAP_RESET, 1'b1, 1'b1, 1, 1'b1,
          '{15'd0, 13'd0, 1'b1}},
        // An identical column that is not selected never counts as a match.
        '{1'b0, MODE_MEAN, GAP_RESET, "A", GAP_RESET, 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_MEAN, GAP_RESET, "C", "C", 1'b0, 1'b1, 1, 1'b1,
          '{15'd0, 13'd0, 1'b0}},
        // Extreme residue codes.
        '{1'b0, MODE_MEAN, GAP_RESET, 8'hFF, 8'hFF, 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_MEAN, GAP_RESET, 8'h00, 8'h00, 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_MEAN, GAP_RESET, 8'hFF, 8'h00, 1'b1, 1'b1, 1, 1'b0, '0},
        // A long alignment drives every counter into saturation.
        '{1'b0, MODE_MEAN, GAP_RESET, "G", "G", 1'b1, 1'b0, 4100, 1'b0, '0},
        '{1'b0, MODE_MEAN, GAP_RESET, "G", "G", 1'b1, 1'b1, 1, 1'b1,
          '{15'd25600, 13'd4096, 1'b0}},
        // Shorter sequence as normalizer.
        '{1'b1, MODE_SHORTER, GAP_RESET, "A", "A", 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_SHORTER, GAP_RESET, "A", GAP_RESET, 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_SHORTER, GAP_RESET, "B", "C", 1'b1, 1'b1, 1, 1'b0, '0},
        // Aligned pairs as normalizer, with no pair at all.
        '{1'b1, MODE_PAIRS, GAP_RESET, "A", GAP_RESET, 1'b1, 1'b1, 1, 1'b1,
          '{15'd0, 13'd0, 1'b1}},
        // Gap code zero.
        '{1'b1, MODE_PAIRS, 8'h00, 8'h00, "A", 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_PAIRS, 8'h00, "A", "A", 1'b0, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_PAIRS, 8'h00, "T", "T", 1'b1, 1'b1, 1, 1'b0, '0},
        // Aligned positions as normalizer, gap code all ones.
        '{1'b1, MODE_POSITIONS, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_POSITIONS, 8'hFF, "A", 8'hFF, 1'b1, 1'b0, 1, 1'b0, '0},
        '{1'b0, MODE_POSITIONS, 8'hFF, "X", "X", 1'b1, 1'b1, 1, 1'b0, '0},
        '{1'b0, MODE_POSITIONS, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1, 1'b1,
          '{15'd0, 13'd0, 1'b1}},
        // Shorter sequence when one sequence has no residue.
        '{1'b1, MODE_SHORTER, GAP_RESET, "A", GAP_RESET, 1'b1, 1'b1, 1, 1'b1,
          '{15'd0, 13'd0, 1'b1}}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = REG_MODE;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    t_in_word          i_in_word   = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_word         o_out_word;

    aligned_sequence_percent_identity i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predictor state: the bench's own copy of both registers and the counters.
    logic [1:0]       norm_mode;
    logic [7:0]       gap_code;
    logic [CNT_W-1:0] n_match;
    logic [CNT_W-1:0] n_res_a;
    logic [CNT_W-1:0] n_res_b;
    logic [CNT_W-1:0] n_pairs;
    logic [CNT_W-1:0] n_positions;

    t_out_word expected_identity [$];
    t_pinned   pinned_results [$];

    int words_taken = 0;
    int words_sent  = 0;
    int error_count = 0;

    // Idle and stall rates in percent, set per phase by the stimulus process.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // The stimulus bumps hold_asked to ask the receiver for one long hold-off.
    int hold_asked   = 0;
    int hold_granted = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
    endfunction

    // Counts one column. On the last column it forms the identity word,
    // queues it and clears the counters for the next alignment.
    task automatic tally_column(input t_in_word w);
        logic            gap_a;
        logic            gap_b;
        longint unsigned num;
        longint unsigned den;
        longint unsigned pct;
        t_out_word       res;
        t_pinned         typed_row;
        gap_a = (w.residue_a == gap_code);
        gap_b = (w.residue_b == gap_code);
        if (!gap_a) n_res_a = bump(n_res_a);
        if (!gap_b) n_res_b = bump(n_res_b);
        if (!(gap_a && gap_b)) n_positions = bump(n_positions);
        if (!gap_a && !gap_b) n_pairs = bump(n_pairs);
        if (w.column_selected && !gap_a && w.residue_a == w.residue_b) n_match = bump(n_match);
        if (!w.last_column) return;

        num = 64'(n_match) * 64'(PCT_SCALE);
        case (norm_mode)
            MODE_SHORTER: begin
                den = (n_res_a < n_res_b) ? 64'(n_res_a) : 64'(n_res_b);
            end
            MODE_MEAN: begin
                // Twice the match count over the summed lengths avoids the halving.
                num = num * 2;
                den = 64'(n_res_a) + 64'(n_res_b);
            end
            MODE_PAIRS: begin
                den = 64'(n_pairs);
            end
            default: begin
                den = 64'(n_positions);
            end
        endcase

        pct = 0;
        if (den != 0) begin
            pct = num / den;
            if (pct > 64'(PCT_SCALE)) pct = 64'(PCT_SCALE);
        end
        res.percent_identity = PCT_W'(pct);
        res.match_count      = n_match;
        res.zero_normalizer  = (den == 0);

        // A directed row may have typed in this word; it then stands in for the prediction.
        if (pinned_results.size() != 0 && pinned_results[0].seq == words_taken) begin
            typed_row = pinned_results.pop_front();
            res = typed_row.word;
        end
        expected_identity.push_back(res);

        n_match     = '0;
        n_res_a     = '0;
        n_res_b     = '0;
        n_pairs     = '0;
        n_positions = '0;
    endtask

    // Monitor: follows register writes, feeds accepted columns to the predictor
    // and scores each accepted identity word against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_out_word due;
        if (!i_rst_n) begin
            norm_mode   = MODE_RESET;
            gap_code    = GAP_RESET;
            n_match     = '0;
            n_res_a     = '0;
            n_res_b     = '0;
            n_pairs     = '0;
            n_positions = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MODE) norm_mode = i_cfg_data[1:0];
                else gap_code = i_cfg_data[7:0];
            end
            if (i_in_valid && o_in_ready) begin
                tally_column(i_in_word);
                words_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_identity.size() == 0) begin
                    $error("identity word with none expected: pct %0d, matches %0d, zero %0b",
                           o_out_word.percent_identity, o_out_word.match_count,
                           o_out_word.zero_normalizer);
                    error_count++;
                end else begin
                    due = expected_identity.pop_front();
                    if (o_out_word.percent_identity !== due.percent_identity) begin
                        $error("percent_identity: expected %0d, got %0d",
                               due.percent_identity, o_out_word.percent_identity);
                        error_count++;
                    end
                    if (o_out_word.match_count !== due.match_count) begin
                        $error("match_count: expected %0d, got %0d",
                               due.match_count, o_out_word.match_count);
                        error_count++;
                    end
                    if (o_out_word.zero_normalizer !== due.zero_normalizer) begin
                        $error("zero_normalizer: expected %0b, got %0b",
                               due.zero_normalizer, o_out_word.zero_normalizer);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls at the phase's rate, or a long hold-off when asked.
    // The hold-off is counted here so that the sender keeps offering columns
    // while the block backs up behind an unread identity word.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_granted != hold_asked) begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: any accepted word or register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("aligned_sequence_percent_identity_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one column, idling first at the sender's rate, and returns at the edge
    // that accepts it. Valid drops between back-to-back columns only when idling.
    task automatic send_word(input t_in_word w);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Waits until every expected identity word is out and the divider has had
    // time to settle, so that the registers may be written.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_identity.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] mode, input logic [7:0] gap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= REG_GAP;
        i_cfg_data  <= gap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Residues favor the gap and a small per-alignment alphabet so that
    // matches and gaps are common, with an occasional arbitrary code.
    function automatic logic [7:0] pick_residue(input logic [7:0] gap,
                                                input logic [3:0][7:0] alpha);
        case ($urandom_range(3)) inside
            0: return gap;
            [1:2]: return alpha[$urandom_range(3)];
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin : stimulus
        t_row             row;
        t_in_word         w;
        logic [3:0][7:0]  alpha;
        logic [7:0]       cur_gap;
        int               len;
        int               taken;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: walk the table, reconfiguring between alignments where asked.
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED[r];
            if (row.set_cfg) begin
                drain();
                write_config(row.mode, row.gap);
            end
            w.residue_a       = row.res_a;
            w.residue_b       = row.res_b;
            w.column_selected = row.sel;
            w.last_column     = row.last;
            if (row.pin) pinned_results.push_back('{words_sent, row.want});
            repeat (row.reps) send_word(w);
        end

        // Random part: one phase per idling pattern, each with fresh register values.
        // The last phase asks for the long receiver hold-off with the sender at full rate.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            cur_gap = ($urandom_range(1) == 0) ? GAP_RESET : 8'($urandom_range(255));
            write_config(2'($urandom_range(3)), cur_gap);
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
                3: begin tx_idle_pct = 26; rx_stall_pct = 26; end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_asked++;
                end
            endcase
            taken = 0;
            while (taken < PHASE_WORDS) begin
                // Mostly short alignments, so that results come often.
                len = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
                for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(255));
                for (int k = 0; k < len; k++) begin
                    w.residue_a       = pick_residue(cur_gap, alpha);
                    w.residue_b       = ($urandom_range(9) < 4) ? w.residue_a
                                                                : pick_residue(cur_gap, alpha);
                    w.column_selected = ($urandom_range(9) != 0);
                    w.last_column     = (k == len - 1);
                    send_word(w);
                    taken++;
                end
            end
        end

        drain();
        if (error_count == 0) begin
            $display("aligned_sequence_percent_identity_tb passed");
        end else begin
            $display("aligned_sequence_percent_identity_tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/aspi_pkg.sv
src/aspi_div.sv
src/aligned_sequence_percent_identity.sv
src/aspi_checker.sv
tb/aligned_sequence_percent_identity_tb.sv
